@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/slns_pkg.sv @@
// ---------------------------------------------------------------------------
// Leaf node store package
// Operation and status codes and the payload types of both channels.
// ---------------------------------------------------------------------------
package slns_pkg;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_SPLIT  = 3'd2;
  localparam logic [2:0] OP_LOCATE = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_SETNXT = 3'd5;
  localparam logic [2:0] OP_GETNXT = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOT_FULL = 3'd2;
  localparam logic [2:0] ST_NO_REC   = 3'd3;
  localparam logic [2:0] ST_BAD_PTR  = 3'd4;

  typedef struct packed {
    logic        [2:0]  op;
    logic signed [31:0] key;
    logic        [30:0] rec_page;
    logic        [30:0] rec_slot;
    logic        [5:0]  index;
    logic signed [31:0] next_page;
  } in_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic        [6:0]  found_index;
    logic signed [31:0] out_key;
    logic        [30:0] out_page;
    logic        [30:0] out_slot;
    logic        [30:0] out_next;
    logic        [6:0]  entry_count;
    logic               last;
  } out_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic        [30:0] page;
    logic        [30:0] slot;
  } entry_t;

endpackage

@@ src/sorted_leaf_node_store.sv @@
// ---------------------------------------------------------------------------
// Sorted leaf node store
// One B+ tree leaf node of sorted key and record-id entries with a next pointer.
// ---------------------------------------------------------------------------
// Usage: raise start with an operation on in_item while busy is low; the
// transfer happens at that clock edge. Results appear on out_item for one
// cycle each, marked by out_valid; the receiver cannot hold them off, and
// out_item.last marks the final result of an operation.
// Clear, set next, get next, rejected inserts and splits, and reads beyond
// the entries answer in the cycle after the transfer. A read in range
// passes through the read state and then into the result register.
// An insert walks the node from the top with one entry RAM port pair,
// comparing and moving one entry per cycle. Locate scans from entry 0 at
// one entry per cycle. A split runs the insert walk, then streams the
// moved-out entries, one per cycle.
// busy stays high until the final result is on the ports, so the next
// transfer can come at the edge that accepts that result.
// The entry RAM's single read port sets the pace of these walks and streams.
// Reset empties the node and invalidates the next pointer; the RAM itself
// is not cleared since entries at or above the fill count never reach a result.
module sorted_leaf_node_store #(
  parameter int NODE_ENTRIES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  slns_pkg::in_t   in_item,
  output logic            out_valid,
  output slns_pkg::out_t  out_item
);

  localparam int AW   = $clog2(NODE_ENTRIES + 1);
  localparam int CW   = $clog2(NODE_ENTRIES + 2);
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam int HALF = (NODE_ENTRIES + 1) / 2;
  localparam int EW   = $bits(slns_pkg::entry_t);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_EPREP = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_LOC   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [30:0]         next_ptr_r, next_ptr_nxt;
  logic                next_vld_r, next_vld_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [30:0]         old_next_r, old_next_nxt;
  slns_pkg::in_t       item_r, item_nxt;
  logic                out_valid_r, out_valid_nxt;
  slns_pkg::out_t      out_r, out_nxt;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  slns_pkg::entry_t    wdata, rdata, new_entry;
  logic [EW-1:0]       rdata_raw;

  logic                accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign rdata     = slns_pkg::entry_t'(rdata_raw);

  assign new_entry.key  = item_r.key;
  assign new_entry.page = item_r.rec_page;
  assign new_entry.slot = item_r.rec_slot;

  slns_entry_ram #(
    .DEPTH (NODE_ENTRIES + 1),
    .AW    (AW),
    .DW    (EW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    next_ptr_nxt  = next_ptr_r;
    next_vld_nxt  = next_vld_r;
    ptr_nxt       = ptr_r;
    old_next_nxt  = old_next_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = ptr_r;
    wdata         = rdata;
    raddr         = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt              = in_item;
          out_nxt               = '0;
          out_nxt.last          = 1'b1;
          out_nxt.entry_count   = 7'(fill_r);
          out_valid_nxt         = 1'b1;
          case (in_item.op)
            slns_pkg::OP_CLEAR: begin
              fill_nxt            = '0;
              next_ptr_nxt        = '0;
              next_vld_nxt        = 1'b0;
              out_nxt.entry_count = '0;
            end
            slns_pkg::OP_INSERT: begin
              if (fill_r == CW'(NODE_ENTRIES)) begin
                out_nxt.status = slns_pkg::ST_FULL;
              end else begin
                // Walk down from the top; the first read is the last entry.
                out_valid_nxt = 1'b0;
                raddr         = AW'(fill_r - CW'(1));
                ptr_nxt       = AW'(fill_r);
                state_nxt     = S_INS;
              end
            end
            slns_pkg::OP_SPLIT: begin
              if (fill_r != CW'(NODE_ENTRIES)) begin
                out_nxt.status = slns_pkg::ST_NOT_FULL;
              end else begin
                out_valid_nxt = 1'b0;
                raddr         = AW'(fill_r - CW'(1));
                ptr_nxt       = AW'(fill_r);
                old_next_nxt  = next_vld_r ? next_ptr_r : '0;
                state_nxt     = S_INS;
              end
            end
            slns_pkg::OP_LOCATE: begin
              out_valid_nxt = 1'b0;
              raddr         = '0;
              ptr_nxt       = '0;
              state_nxt     = S_LOC;
            end
            slns_pkg::OP_READ: begin
              if (CMPW'(in_item.index) >= CMPW'(fill_r)) begin
                out_nxt.status = slns_pkg::ST_NO_REC;
              end else begin
                out_valid_nxt = 1'b0;
                raddr         = AW'(in_item.index);
                state_nxt     = S_RD;
              end
            end
            slns_pkg::OP_SETNXT: begin
              if (in_item.next_page[31]) begin
                out_nxt.status = slns_pkg::ST_BAD_PTR;
              end else begin
                next_ptr_nxt = in_item.next_page[30:0];
                next_vld_nxt = 1'b1;
              end
            end
            slns_pkg::OP_GETNXT: begin
              if (!next_vld_r) begin
                out_nxt.status = slns_pkg::ST_BAD_PTR;
              end else begin
                out_nxt.out_next = next_ptr_r;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        // rdata holds the entry just below ptr_r.
        we = 1'b1;
        if ((ptr_r == '0) || !($signed(rdata.key) > $signed(item_r.key))) begin
          wdata = new_entry;
          if (item_r.op == slns_pkg::OP_SPLIT) begin
            state_nxt = S_EPREP;
          end else begin
            fill_nxt                = fill_r + CW'(1);
            out_nxt                 = '0;
            out_nxt.found_index     = 7'(ptr_r);
            out_nxt.entry_count     = 7'(fill_r + CW'(1));
            out_nxt.last            = 1'b1;
            out_valid_nxt           = 1'b1;
            state_nxt               = S_IDLE;
          end
        end else begin
          wdata   = rdata;
          ptr_nxt = ptr_r - AW'(1);
          raddr   = ptr_r - AW'(2);
        end
      end

      S_EPREP: begin
        raddr        = AW'(HALF);
        ptr_nxt      = AW'(HALF);
        fill_nxt     = CW'(HALF);
        next_ptr_nxt = '0;
        next_vld_nxt = 1'b0;
        state_nxt    = S_EMIT;
      end

      S_EMIT: begin
        raddr               = ptr_r + AW'(1);
        out_nxt             = '0;
        out_nxt.out_key     = rdata.key;
        out_nxt.out_page    = rdata.page;
        out_nxt.out_slot    = rdata.slot;
        out_nxt.out_next    = old_next_r;
        out_nxt.entry_count = 7'(fill_r);
        out_nxt.last        = (ptr_r == AW'(NODE_ENTRIES));
        out_valid_nxt       = 1'b1;
        ptr_nxt             = ptr_r + AW'(1);
        if (ptr_r == AW'(NODE_ENTRIES)) begin
          state_nxt = S_IDLE;
        end
      end

      S_LOC: begin
        out_nxt             = '0;
        out_nxt.found_index = 7'(ptr_r);
        out_nxt.entry_count = 7'(fill_r);
        out_nxt.last        = 1'b1;
        out_nxt.status      = slns_pkg::ST_NO_REC;
        if (CW'(ptr_r) == fill_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if ($signed(rdata.key) < $signed(item_r.key)) begin
          ptr_nxt = ptr_r + AW'(1);
          raddr   = ptr_r + AW'(1);
        end else begin
          if (rdata.key == item_r.key) begin
            out_nxt.status = slns_pkg::ST_OK;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_RD: begin
        out_nxt             = '0;
        out_nxt.out_key     = rdata.key;
        out_nxt.out_page    = rdata.page;
        out_nxt.out_slot    = rdata.slot;
        out_nxt.entry_count = 7'(fill_r);
        out_nxt.last        = 1'b1;
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      next_ptr_r  <= '0;
      next_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      next_ptr_r  <= next_ptr_nxt;
      next_vld_r  <= next_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    old_next_r <= old_next_nxt;
    item_r     <= item_nxt;
    out_r      <= out_nxt;
  end

endmodule

@@ src/slns_entry_ram.sv @@
// ---------------------------------------------------------------------------
// Entry RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module slns_entry_ram #(
  parameter int DEPTH = 65,
  parameter int AW    = 7,
  parameter int DW    = 94
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/slns_checker.sv @@
// ---------------------------------------------------------------------------
// Leaf node store checker
// Port-level checks on the command and result channels.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slns_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input slns_pkg::in_t  in_item,
  input logic           out_valid,
  input slns_pkg::out_t out_item
);

  logic clear_xfer;
  logic clear_done;
  logic run_more;
  logic run_end;

  assign clear_xfer = start && !busy && (in_item.op == slns_pkg::OP_CLEAR);
  assign clear_done = out_valid && out_item.last && (out_item.entry_count == 7'd0);
  assign run_more   = out_valid && !out_item.last;
  assign run_end    = out_valid && out_item.last;

  `ASSERT_NEXT(a_clear_answers, clk, rst_n, clear_xfer, clear_done)
  `ASSERT_NEXT(a_run_unbroken, clk, rst_n, run_more, out_valid)
  `ASSERT_IMPLY(a_last_frees, clk, rst_n, run_end, !busy)
  `ASSERT_IMPLY(a_status_range, clk, rst_n, out_valid, out_item.status <= slns_pkg::ST_BAD_PTR)

endmodule

bind sorted_leaf_node_store slns_checker u_slns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

@@ sim/sorted_leaf_node_store_test.sv @@
// ---------------------------------------------------------------------------
// Sorted leaf node store testbench
// Drives leaf node operations through the command port, predicts every
// result with a behavioral model of the node and checks each whole result,
// in order, against the oldest prediction, listing its fields on a mismatch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_leaf_node_store_test;

  localparam int NODE_ENTRIES = 64;
  localparam int HALF         = (NODE_ENTRIES + 1) / 2;
  localparam int WATCHDOG     = 20000;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  slns_pkg::in_t   in_item;
  logic            out_valid;
  slns_pkg::out_t  out_item;

  sorted_leaf_node_store #(.NODE_ENTRIES(NODE_ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Model state of the node.
  slns_pkg::entry_t node_entries[NODE_ENTRIES + 1];
  int unsigned      node_fill;
  logic [30:0]      node_next;
  logic             node_next_ok;

  // Results still to come, oldest first.
  slns_pkg::out_t   pending_results[$];
  int               error_count;
  int               items_sent;
  int               results_seen;
  int               splits_seen;
  int               send_idle_pct;
  int               idle_cycles;

  // Builds a single-result answer; the count field is the fill after the operation.
  function automatic slns_pkg::out_t one_result(logic [2:0] st, logic [6:0] idx,
                                                logic [30:0] nxt);
    slns_pkg::out_t r;
    r = '0;
    r.status      = st;
    r.found_index = idx;
    r.out_next    = nxt;
    r.entry_count = node_fill[6:0];
    r.last        = 1'b1;
    return r;
  endfunction

  // Predicts the results of one operation and updates the model node.
  task automatic predict_node_op(input slns_pkg::in_t it);
    int unsigned    pos;
    logic [30:0]    old_next;
    slns_pkg::out_t r;
    case (it.op)
      slns_pkg::OP_CLEAR: begin
        node_fill = 0;
        node_next = '0;
        node_next_ok = 1'b0;
        pending_results.push_back(one_result(slns_pkg::ST_OK, '0, '0));
      end
      slns_pkg::OP_INSERT, slns_pkg::OP_SPLIT: begin
        if (it.op == slns_pkg::OP_INSERT && node_fill >= NODE_ENTRIES) begin
          pending_results.push_back(one_result(slns_pkg::ST_FULL, '0, '0));
        end else if (it.op == slns_pkg::OP_SPLIT && node_fill < NODE_ENTRIES) begin
          pending_results.push_back(one_result(slns_pkg::ST_NOT_FULL, '0, '0));
        end else begin
          // Equal keys keep arrival order: the new entry goes after them.
          pos = 0;
          while (pos < node_fill && node_entries[pos].key <= it.key) pos++;
          for (int j = node_fill; j > pos; j--) node_entries[j] = node_entries[j - 1];
          node_entries[pos] = '{key: it.key, page: it.rec_page, slot: it.rec_slot};
          node_fill++;
          if (it.op == slns_pkg::OP_INSERT) begin
            pending_results.push_back(one_result(slns_pkg::ST_OK, pos[6:0], '0));
          end else begin
            splits_seen++;
            old_next = node_next_ok ? node_next : '0;
            node_fill = HALF;
            node_next = '0;
            node_next_ok = 1'b0;
            for (int k = HALF; k <= NODE_ENTRIES; k++) begin
              r = '0;
              r.out_key     = node_entries[k].key;
              r.out_page    = node_entries[k].page;
              r.out_slot    = node_entries[k].slot;
              r.out_next    = old_next;
              r.entry_count = node_fill[6:0];
              r.last        = (k == NODE_ENTRIES);
              pending_results.push_back(r);
            end
          end
        end
      end
      slns_pkg::OP_LOCATE: begin
        pos = 0;
        while (pos < node_fill && node_entries[pos].key < it.key) pos++;
        if (pos < node_fill && node_entries[pos].key == it.key)
          pending_results.push_back(one_result(slns_pkg::ST_OK, pos[6:0], '0));
        else
          pending_results.push_back(one_result(slns_pkg::ST_NO_REC, pos[6:0], '0));
      end
      slns_pkg::OP_READ: begin
        if (it.index >= node_fill) begin
          pending_results.push_back(one_result(slns_pkg::ST_NO_REC, '0, '0));
        end else begin
          r = one_result(slns_pkg::ST_OK, '0, '0);
          r.out_key  = node_entries[it.index].key;
          r.out_page = node_entries[it.index].page;
          r.out_slot = node_entries[it.index].slot;
          pending_results.push_back(r);
        end
      end
      slns_pkg::OP_SETNXT: begin
        if (it.next_page < 0) begin
          pending_results.push_back(one_result(slns_pkg::ST_BAD_PTR, '0, '0));
        end else begin
          node_next = it.next_page[30:0];
          node_next_ok = 1'b1;
          pending_results.push_back(one_result(slns_pkg::ST_OK, '0, '0));
        end
      end
      slns_pkg::OP_GETNXT: begin
        if (node_next_ok)
          pending_results.push_back(one_result(slns_pkg::ST_OK, '0, node_next));
        else
          pending_results.push_back(one_result(slns_pkg::ST_BAD_PTR, '0, '0));
      end
      default: begin
        pending_results.push_back(one_result(slns_pkg::ST_OK, '0, '0));
      end
    endcase
  endtask

  // Sends one operation: random idle gaps, then holds start until the transfer.
  // start is driven with blocking assignments, so dropping it and raising it
  // again for the next operation at the same falling edge leaves it high.
  task automatic send_op(input slns_pkg::in_t it);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    start   = 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_node_op(it);
    items_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Result checker: every strobed result is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        error_count++;
      end else begin
        if (pending_results[0] !== out_item) begin
          $display("%0t: mismatch expected %h actual %h", $time, pending_results[0], out_item);
          $display("  status %0d/%0d idx %0d/%0d key %0d/%0d page %0d/%0d slot %0d/%0d",
                   pending_results[0].status, out_item.status,
                   pending_results[0].found_index, out_item.found_index,
                   pending_results[0].out_key, out_item.out_key,
                   pending_results[0].out_page, out_item.out_page,
                   pending_results[0].out_slot, out_item.out_slot);
          $display("  next %0d/%0d count %0d/%0d last %0d/%0d",
                   pending_results[0].out_next, out_item.out_next,
                   pending_results[0].entry_count, out_item.entry_count,
                   pending_results[0].last, out_item.last);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog: counts cycles with no transfer and no result.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic slns_pkg::in_t make_op(logic [2:0] op, logic signed [31:0] key);
    slns_pkg::in_t it;
    it.op        = op;
    it.key       = key;
    it.rec_page  = 31'($urandom);
    it.rec_slot  = 31'($urandom);
    it.index     = 6'($urandom);
    it.next_page = 32'($urandom);
    return it;
  endfunction

  // Keys from a narrow pool give many duplicates; some are the two extremes, the rest full range.
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(3))
      0: return 32'($urandom_range(15)) - 32'sd8;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Directed cases: the extreme keys and the corner cases of an almost empty node.
  task automatic test_directed();
    slns_pkg::in_t it;
    send_op(make_op(slns_pkg::OP_GETNXT, 0));          // invalid pointer after reset
    send_op(make_op(slns_pkg::OP_LOCATE, 5));          // empty node
    it = make_op(slns_pkg::OP_READ, 0); it.index = 0;  send_op(it);
    send_op(make_op(slns_pkg::OP_SPLIT, 0));           // node not full
    send_op(make_op(slns_pkg::OP_INSERT, 32'sh7fffffff));
    send_op(make_op(slns_pkg::OP_INSERT, 32'sh80000000));
    send_op(make_op(slns_pkg::OP_INSERT, 0));
    it = make_op(slns_pkg::OP_INSERT, 0); it.rec_page = '1; it.rec_slot = '1; send_op(it);
    send_op(make_op(slns_pkg::OP_LOCATE, 32'sh80000000)); // match at entry 0
    send_op(make_op(slns_pkg::OP_LOCATE, 1));
    send_op(make_op(slns_pkg::OP_LOCATE, 32'sh7fffffff));
    it = make_op(slns_pkg::OP_READ, 0); it.index = 2;  send_op(it);
    it = make_op(slns_pkg::OP_READ, 0); it.index = 63; send_op(it);
    it = make_op(slns_pkg::OP_SETNXT, 0); it.next_page = 32'sh80000000; send_op(it);
    it = make_op(slns_pkg::OP_SETNXT, 0); it.next_page = 32'sh7fffffff; send_op(it);
    send_op(make_op(slns_pkg::OP_GETNXT, 0));
    send_op(make_op(3'd7, 0));                         // unused code
    send_op(make_op(slns_pkg::OP_CLEAR, 0));
    send_op(make_op(slns_pkg::OP_GETNXT, 0));
    it = make_op(slns_pkg::OP_SETNXT, 0); it.next_page = 0; send_op(it);
    send_op(make_op(slns_pkg::OP_GETNXT, 0));
  endtask

  // Fills the node, checks the full cases and splits it.
  task automatic test_fill_and_split(input int dup_pool);
    slns_pkg::in_t it;
    send_op(make_op(slns_pkg::OP_CLEAR, 0));
    it = make_op(slns_pkg::OP_SETNXT, 0); it.next_page[31] = 1'b0; send_op(it);
    while (node_fill < NODE_ENTRIES)
      send_op(make_op(slns_pkg::OP_INSERT,
                      dup_pool ? 32'($urandom_range(dup_pool)) : pick_key()));
    send_op(make_op(slns_pkg::OP_INSERT, 3));          // full
    it = make_op(slns_pkg::OP_READ, 0); it.index = 63; send_op(it);
    send_op(make_op(slns_pkg::OP_SPLIT,
                    dup_pool ? 32'($urandom_range(dup_pool)) : pick_key()));
    send_op(make_op(slns_pkg::OP_GETNXT, 0));
  endtask

  // Random mix, biased toward inserts so the node fills and splits.
  task automatic test_random(input int count);
    logic [2:0] op;
    int         r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45) op = slns_pkg::OP_INSERT;
      else if (r < 55) op = slns_pkg::OP_LOCATE;
      else if (r < 68) op = slns_pkg::OP_READ;
      else if (r < 74) op = slns_pkg::OP_SETNXT;
      else if (r < 80) op = slns_pkg::OP_GETNXT;
      else if (r < 90)
        op = (node_fill == NODE_ENTRIES) ? slns_pkg::OP_SPLIT : slns_pkg::OP_INSERT;
      else if (r < 93) op = slns_pkg::OP_SPLIT;
      else if (r < 95) op = slns_pkg::OP_CLEAR;
      else op = 3'($urandom);
      send_op(make_op(op, pick_key()));
      if (n == count / 2) wait_drained();    // pause until everything is back
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_item       = '0;
    error_count   = 0;
    items_sent    = 0;
    results_seen  = 0;
    splits_seen   = 0;
    send_idle_pct = 11;
    idle_cycles   = 0;
    node_fill     = 0;
    node_next     = '0;
    node_next_ok  = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_fill_and_split(0);
    test_random(40);
    send_idle_pct = 59;
    test_fill_and_split(6);
    test_random(30);
    send_idle_pct = 0;
    test_fill_and_split(0);
    test_random(30);

    wait_drained();
    repeat (200) @(negedge clk);
    $display("Sent %0d operations and checked %0d results across %0d full-node splits.",
             items_sent, results_seen, splits_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sorted_leaf_node_store.f @@
+incdir+src
src/slns_pkg.sv
src/slns_entry_ram.sv
src/sorted_leaf_node_store.sv
src/slns_checker.sv
sim/sorted_leaf_node_store_test.sv
